// ===== rtl/dtmr_pkg.sv =====
`timescale 1ns / 1ps

package dtmr_pkg;

   localparam int DivPrescale   = 64;
   localparam int PrescaleWidth = (DivPrescale > 1) ? $clog2(DivPrescale) : 1;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   localparam logic [2:0] REG_DIV   = 3'd0;
   localparam logic [2:0] REG_TIMA  = 3'd1;
   localparam logic [2:0] REG_TMA   = 3'd2;
   localparam logic [2:0] REG_TAC   = 3'd3;
   localparam logic [2:0] REG_FLAGS = 3'd4;

   localparam int         TimerEnableBit = 2;
   localparam logic [7:0] TimerIrqMask   = 8'h04;
   localparam logic [7:0] FlagsSetMask   = 8'hE0;
   localparam logic [7:0] DividerReset   = 8'h18;
   localparam logic [7:0] ControlReset   = 8'hF8;

   typedef struct packed {
      logic [1:0] opcode;
      logic [2:0] reg_select;
      logic [7:0] write_data;
   } item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [7:0] irq_flags;
   } result_type;

   function automatic logic [8:0] period_of(input logic [1:0] rate_sel);
      logic [8:0] period;
      unique case (rate_sel)
         2'd0:    period = 9'd256;
         2'd1:    period = 9'd4;
         2'd2:    period = 9'd16;
         default: period = 9'd64;
      endcase
      return period;
   endfunction

endpackage

// ===== rtl/divider_timer_with_overflow_irq.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Ports                                        Handshake
// req       in         req_opcode, req_reg_select, req_write_data   req_valid / req_stall
// rsp       out        rsp_read_data, rsp_irq_flags                 rsp_valid / rsp_stall
//
// One transaction is taken every clock unless a stall holds it; it is held in the input register,
// which feeds the register file and counters, and its response is held in the result register,
// loaded as the counters update. Reset is synchronous and loads the register reset values.
// A stalled response holds the result register, and req_stall follows in the same cycle
// only once the input register is also occupied.

module divider_timer_with_overflow_irq (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_opcode,
   input  logic [2:0] req_reg_select,
   input  logic [7:0] req_write_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic [7:0] rsp_irq_flags
);
   import dtmr_pkg::*;

   logic       item_valid;
   item_type   item;
   result_type result;
   logic       out_ready;
   logic       fire;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;

   assign out_ready    = !rsp_valid_ff || !rsp_stall;
   assign fire         = item_valid && out_ready;
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   dtmr_in_stage u_in_stage (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_opcode     (req_opcode),
      .req_reg_select (req_reg_select),
      .req_write_data (req_write_data),
      .req_stall      (req_stall),
      .advance        (fire),
      .item_valid     (item_valid),
      .item           (item)
   );

   dtmr_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_ff.read_data;
   assign rsp_irq_flags = rsp_ff.irq_flags;

   a_fire_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("Executed transaction produced no response.");

   a_stall_needs_item : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> item_valid)
      else $error("Request stalled with an empty input register.");

   a_non_read_zero : assert property (@(posedge clock) disable iff (reset)
      fire && (item.opcode != OP_READ) |=> rsp_read_data == 8'd0)
      else $error("Non-read transaction returned nonzero read data.");

endmodule

// ===== rtl/dtmr_in_stage.sv =====
`timescale 1ns / 1ps

module dtmr_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [1:0]         req_opcode,
   input  logic [2:0]         req_reg_select,
   input  logic [7:0]         req_write_data,
   output logic               req_stall,
   input  logic               advance,
   output logic               item_valid,
   output dtmr_pkg::item_type item
);
   import dtmr_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     accept;

   assign req_stall  = valid_ff && !advance;
   assign accept     = req_valid && !req_stall;
   assign valid_in   = accept || (valid_ff && !advance);
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.opcode     <= req_opcode;
         item_ff.reg_select <= req_reg_select;
         item_ff.write_data <= req_write_data;
      end
   end

endmodule

// ===== rtl/dtmr_core.sv =====
`timescale 1ns / 1ps

module dtmr_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  dtmr_pkg::item_type   item,
   output dtmr_pkg::result_type result
);
   import dtmr_pkg::*;

   logic [PrescaleWidth-1:0] prescale_ff, prescale_in;
   logic [7:0]               divider_ff, divider_in;
   logic [8:0]               period_count_ff, period_count_in;
   logic [7:0]               timer_ff, timer_in;
   logic [7:0]               reload_ff, reload_in;
   logic [7:0]               control_ff, control_in;
   logic [7:0]               flags_ff, flags_in;

   logic [PrescaleWidth:0] prescale_inc;
   logic [8:0]             period_inc;
   logic [8:0]             period;
   logic [7:0]             timer_inc;
   logic [7:0]             read_byte;

   assign prescale_inc = {1'b0, prescale_ff} + 1'b1;
   assign period       = period_of(control_ff[1:0]);
   assign period_inc   = period_count_ff + 9'd1;
   assign timer_inc    = timer_ff + 8'd1;

   always_comb begin
      unique case (item.reg_select)
         REG_DIV:   read_byte = divider_ff;
         REG_TIMA:  read_byte = timer_ff;
         REG_TMA:   read_byte = reload_ff;
         REG_TAC:   read_byte = control_ff;
         REG_FLAGS: read_byte = flags_ff;
         default:   read_byte = 8'd0;
      endcase
   end

   always_comb begin
      prescale_in     = prescale_ff;
      divider_in      = divider_ff;
      period_count_in = period_count_ff;
      timer_in        = timer_ff;
      reload_in       = reload_ff;
      control_in      = control_ff;
      flags_in        = flags_ff;
      result.read_data = 8'd0;

      unique case (item.opcode)
         OP_TICK: begin
            if (prescale_inc >= (PrescaleWidth + 1)'(DivPrescale)) begin
               prescale_in = '0;
               divider_in  = divider_ff + 8'd1;
            end else begin
               prescale_in = prescale_inc[PrescaleWidth-1:0];
            end
            if (control_ff[TimerEnableBit]) begin
               if (period_inc >= period) begin
                  period_count_in = period_inc - period;
                  if (timer_inc == 8'd0) begin
                     timer_in = reload_ff;
                     flags_in = flags_ff | TimerIrqMask;
                  end else begin
                     timer_in = timer_inc;
                  end
               end else begin
                  period_count_in = period_inc;
               end
            end
         end
         OP_READ: begin
            result.read_data = read_byte;
         end
         OP_WRITE: begin
            unique case (item.reg_select)
               REG_DIV: begin
                  divider_in  = 8'd0;
                  prescale_in = '0;
               end
               REG_TIMA:  timer_in   = item.write_data;
               REG_TMA:   reload_in  = item.write_data;
               REG_TAC:   control_in = item.write_data;
               REG_FLAGS: flags_in   = item.write_data | FlagsSetMask;
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase

      result.irq_flags = flags_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff     <= '0;
         divider_ff      <= DividerReset;
         period_count_ff <= 9'd0;
         timer_ff        <= 8'd0;
         reload_ff       <= 8'd0;
         control_ff      <= ControlReset;
         flags_ff        <= 8'd0;
      end else if (fire) begin
         prescale_ff     <= prescale_in;
         divider_ff      <= divider_in;
         period_count_ff <= period_count_in;
         timer_ff        <= timer_in;
         reload_ff       <= reload_in;
         control_ff      <= control_in;
         flags_ff        <= flags_in;
      end
   end

endmodule
